/* hdl/pspec_pkg.sv */
// Shared constants for the printf format specifier parser.
package pspec_pkg;

  localparam int unsigned CH_BITS     = 8;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned CONV_BITS   = 3;
  localparam int unsigned FLAG_BITS   = 6;
  localparam int unsigned LEN_BITS    = 4;
  localparam int unsigned FWID_BITS   = 16;
  localparam int unsigned PREC_BITS   = 17;
  localparam int unsigned DIGIT_BITS  = 4;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_END     = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_UNKNOWN = 2'd2;

  // Conversion classes
  localparam logic [CONV_BITS-1:0] CT_NONE  = 3'd0;
  localparam logic [CONV_BITS-1:0] CT_INT   = 3'd1;
  localparam logic [CONV_BITS-1:0] CT_FLOAT = 3'd2;
  localparam logic [CONV_BITS-1:0] CT_CHAR  = 3'd3;
  localparam logic [CONV_BITS-1:0] CT_STR   = 3'd4;
  localparam logic [CONV_BITS-1:0] CT_PTR   = 3'd5;

  // Flag bit positions
  localparam int unsigned FL_ALT   = 0;
  localparam int unsigned FL_ZERO  = 1;
  localparam int unsigned FL_LEFT  = 2;
  localparam int unsigned FL_SPACE = 3;
  localparam int unsigned FL_PLUS  = 4;
  localparam int unsigned FL_GROUP = 5;

  // Length bit positions
  localparam int unsigned LN_SHORT = 0;
  localparam int unsigned LN_LONG  = 1;
  localparam int unsigned LN_LLONG = 2;
  localparam int unsigned LN_LDBL  = 3;

  // Characters with special meaning
  localparam logic [CH_BITS-1:0] CH_NUL  = 8'h00;
  localparam logic [CH_BITS-1:0] CH_PCT  = "%";
  localparam logic [CH_BITS-1:0] CH_ZERO = "0";
  localparam logic [CH_BITS-1:0] CH_ONE  = "1";
  localparam logic [CH_BITS-1:0] CH_NINE = "9";
  localparam logic [CH_BITS-1:0] CH_DOT  = ".";

endpackage

/* hdl/printf_spec_parser.sv */
// printf format specifier parser: input register, phase/field logic, result register.
//
// Takes one format string character per transaction (0 ends the string) and returns one
// result transaction per conversion spec, per string end, or per unknown conversion
// character; plain text and "%%" produce nothing. It accepts a character every clock
// cycle unless the held character has a result that waits on a stalled output; a result
// passes through the input register and then the result register. The parse phase and
// the times-ten width/precision accumulators are updated per character; the accumulators
// saturate at 2^NUM_WIDTH-1 and are then cut to the 16-bit width and 17-bit precision
// outputs. A character can be taken while a finished result waits on a stalled output.
module printf_spec_parser
  import pspec_pkg::*;
#(
  parameter int unsigned NUM_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          ch_valid,
  output logic                          ch_stall,
  input  logic        [CH_BITS-1:0]     ch,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic        [STATUS_BITS-1:0] status,
  output logic        [CH_BITS-1:0]     letter,
  output logic        [CONV_BITS-1:0]   conv_type,
  output logic        [FLAG_BITS-1:0]   flag_bits,
  output logic        [LEN_BITS-1:0]    length_bits,
  output logic        [FWID_BITS-1:0]   field_width,
  output logic signed [PREC_BITS-1:0]   precision
);

  typedef enum logic [2:0] {
    PH_SCAN,
    PH_FLAGS,
    PH_WIDTH,
    PH_DOT,
    PH_PREC,
    PH_LEN
  } phase_t;

  // accumulate one decimal digit with saturation at all ones
  function automatic logic [NUM_WIDTH-1:0] add_digit(input logic [NUM_WIDTH-1:0] acc,
                                                      input logic [DIGIT_BITS-1:0] d);
    logic [NUM_WIDTH+3:0] acc_ext;
    logic [NUM_WIDTH+3:0] sum;
    acc_ext = {4'b0, acc};
    sum = (acc_ext << 3) + (acc_ext << 1) + {{NUM_WIDTH{1'b0}}, d};
    if (sum[NUM_WIDTH+3:NUM_WIDTH] != 4'b0) begin
      return {NUM_WIDTH{1'b1}};
    end
    return sum[NUM_WIDTH-1:0];
  endfunction

  // input register
  logic               s1_valid;
  logic [CH_BITS-1:0] s1_ch;
  logic               s1_adv;
  logic               ch_accept;

  // parse state
  phase_t               phase, phase_next;
  logic [FLAG_BITS-1:0] flags, flags_next;
  logic [NUM_WIDTH-1:0] width_acc, width_acc_next;
  logic [NUM_WIDTH-1:0] prec_acc, prec_acc_next;
  logic                 prec_given, prec_given_next;
  logic [LEN_BITS-1:0]  len, len_next;

  // result of the character in the input register
  logic                   emit;
  logic [STATUS_BITS-1:0] r_status;
  logic [CONV_BITS-1:0]   r_conv;
  logic [LEN_BITS-1:0]    r_len;
  logic                   r_end;

  logic [NUM_WIDTH+FWID_BITS-1:0] width_ext;
  logic [NUM_WIDTH+PREC_BITS-1:0] prec_ext;

  logic                  is_digit;
  logic                  is_nz_digit;
  logic [DIGIT_BITS-1:0] digit;
  logic                  to_dotchk;
  logic                  to_len;
  logic                  to_conv;

  assign ch_accept   = ch_valid && !ch_stall;
  assign is_digit    = (s1_ch >= CH_ZERO) && (s1_ch <= CH_NINE);
  assign is_nz_digit = (s1_ch >= CH_ONE) && (s1_ch <= CH_NINE);
  assign digit       = s1_ch[DIGIT_BITS-1:0];

  always_comb begin
    phase_next      = phase;
    flags_next      = flags;
    width_acc_next  = width_acc;
    prec_acc_next   = prec_acc;
    prec_given_next = prec_given;
    len_next        = len;
    emit            = 1'b0;
    r_status        = ST_OK;
    r_conv          = CT_NONE;
    r_len           = len;
    r_end           = 1'b0;
    to_dotchk       = 1'b0;
    to_len          = 1'b0;
    to_conv         = 1'b0;

    if (s1_ch == CH_NUL) begin
      emit       = 1'b1;
      r_end      = 1'b1;
      r_status   = ST_END;
      phase_next = PH_SCAN;
    end else begin
      case (phase)
        PH_SCAN: begin
          if (s1_ch == CH_PCT) begin
            flags_next      = '0;
            width_acc_next  = '0;
            prec_acc_next   = '0;
            prec_given_next = 1'b0;
            len_next        = '0;
            phase_next      = PH_FLAGS;
          end
        end
        PH_FLAGS: begin
          case (s1_ch)
            "#":  flags_next[FL_ALT]   = 1'b1;
            "0":  flags_next[FL_ZERO]  = 1'b1;
            "-":  flags_next[FL_LEFT]  = 1'b1;
            " ":  flags_next[FL_SPACE] = 1'b1;
            "+":  flags_next[FL_PLUS]  = 1'b1;
            "'":  flags_next[FL_GROUP] = 1'b1;
            default: begin
              if (is_nz_digit) begin
                width_acc_next = add_digit('0, digit);
                phase_next     = PH_WIDTH;
              end else begin
                to_dotchk = 1'b1;
              end
            end
          endcase
        end
        PH_WIDTH: begin
          if (is_digit) begin
            width_acc_next = add_digit(width_acc, digit);
          end else begin
            to_dotchk = 1'b1;
          end
        end
        PH_DOT: begin
          if (is_digit) begin
            prec_acc_next   = add_digit('0, digit);
            prec_given_next = 1'b1;
            phase_next      = PH_PREC;
          end else begin
            to_len = 1'b1;
          end
        end
        PH_PREC: begin
          if (is_digit) begin
            prec_acc_next = add_digit(prec_acc, digit);
          end else begin
            to_len = 1'b1;
          end
        end
        PH_LEN: begin
          to_len = 1'b1;
        end
        default: begin
          phase_next = PH_SCAN;
        end
      endcase

      if (to_dotchk) begin
        if (s1_ch == CH_DOT) begin
          phase_next = PH_DOT;
        end else begin
          to_len = 1'b1;
        end
      end

      if (to_len) begin
        phase_next = PH_LEN;
        case (s1_ch)
          "h": len_next[LN_SHORT] = 1'b1;
          "l": begin
            if (len[LN_LONG]) begin
              len_next[LN_LLONG] = 1'b1;
            end else begin
              len_next[LN_LONG] = 1'b1;
            end
          end
          "L": len_next[LN_LDBL]  = 1'b1;
          "q": len_next[LN_LLONG] = 1'b1;
          "j", "z", "t": ;
          default: to_conv = 1'b1;
        endcase
      end

      if (to_conv) begin
        phase_next = PH_SCAN;
        emit       = 1'b1;
        case (s1_ch)
          "d", "i", "o", "u", "x", "X", "n": r_conv = CT_INT;
          "e", "E", "f", "F", "g", "G", "a", "A": r_conv = CT_FLOAT;
          "c": r_conv = CT_CHAR;
          "s": r_conv = CT_STR;
          "p": r_conv = CT_PTR;
          "C": begin
            r_conv        = CT_CHAR;
            r_len[LN_LONG] = 1'b1;
          end
          "S": begin
            r_conv        = CT_STR;
            r_len[LN_LONG] = 1'b1;
          end
          "%": emit = 1'b0;
          default: r_status = ST_UNKNOWN;
        endcase
      end
    end
  end

  // a character with no result may move on even when the output is blocked
  assign s1_adv   = s1_valid && (!emit || !res_valid || !res_stall);
  assign ch_stall = s1_valid && !s1_adv;

  assign width_ext = {{FWID_BITS{1'b0}}, width_acc};
  assign prec_ext  = {{PREC_BITS{1'b0}}, prec_acc};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      res_valid  <= 1'b0;
      phase      <= PH_SCAN;
      flags      <= '0;
      width_acc  <= '0;
      prec_acc   <= '0;
      prec_given <= 1'b0;
      len        <= '0;
    end else begin
      if (ch_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv) begin
        phase      <= phase_next;
        flags      <= flags_next;
        width_acc  <= width_acc_next;
        prec_acc   <= prec_acc_next;
        prec_given <= prec_given_next;
        len        <= len_next;
      end

      if (s1_adv && emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ch_accept) begin
      s1_ch <= ch;
    end
    if (s1_adv && emit) begin
      status <= r_status;
      if (r_end) begin
        letter      <= '0;
        conv_type   <= CT_NONE;
        flag_bits   <= '0;
        length_bits <= '0;
        field_width <= '0;
        precision   <= '1;
      end else begin
        letter      <= s1_ch;
        conv_type   <= r_conv;
        flag_bits   <= flags;
        length_bits <= r_len;
        field_width <= width_ext[FWID_BITS-1:0];
        precision   <= prec_given ? prec_ext[PREC_BITS-1:0] : '1;
      end
    end
  end

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (status == ST_OK || status == ST_END || status == ST_UNKNOWN))
    else $error("undefined result status");

  a_end_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_END |-> letter == CH_NUL && precision == '1 &&
                                     conv_type == CT_NONE)
    else $error("string end result carries spec fields");

  a_unknown_type: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_UNKNOWN |-> conv_type == CT_NONE)
    else $error("unknown conversion with a type");

  a_ok_type: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_OK |-> conv_type != CT_NONE)
    else $error("parsed spec without a type");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (rst)
    ch_stall |-> s1_valid && emit && res_valid && res_stall)
    else $error("input stalled without a blocked result");

  a_nul_rescans: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_ch == CH_NUL |=> phase == PH_SCAN)
    else $error("string end did not return to scanning");

endmodule

/* bench/tb_printf_spec_parser.sv */
// Self-checking testbench for printf_spec_parser: directed and random format strings vs. a predictor.
module tb_printf_spec_parser;
  import pspec_pkg::*;

  localparam int NUM_WIDTH = 16;
  localparam int ACC_MAX = (1 << NUM_WIDTH) - 1;
  localparam int ITEMS = 1650;
  localparam logic signed [PREC_BITS-1:0] PREC_NONE = -17'sd1;

  typedef enum int {PP_HUNT, PP_FLAGS, PP_WIDTH, PP_DOT, PP_PREC, PP_LEN, PP_DOTCHK}
    parse_phase_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]      status;
    logic [CH_BITS-1:0]          letter;
    logic [CONV_BITS-1:0]        conv;
    logic [FLAG_BITS-1:0]        flags;
    logic [LEN_BITS-1:0]         len;
    logic [FWID_BITS-1:0]        fwidth;
    logic signed [PREC_BITS-1:0] prec;
  } spec_res_t;

  typedef struct {
    bit        on;
    spec_res_t v;
  } typed_spec_t;

  typedef struct {
    string     txt;
    bit        nul_end;
    bit        typed;
    spec_res_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic ch_valid = 1'b0;
  logic ch_stall;
  logic [CH_BITS-1:0] ch = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic [STATUS_BITS-1:0] status;
  logic [CH_BITS-1:0] letter;
  logic [CONV_BITS-1:0] conv_type;
  logic [FLAG_BITS-1:0] flag_bits;
  logic [LEN_BITS-1:0] length_bits;
  logic [FWID_BITS-1:0] field_width;
  logic signed [PREC_BITS-1:0] precision;

  printf_spec_parser #(.NUM_WIDTH(NUM_WIDTH)) DUT (
    .clk(clk), .rst(rst),
    .ch_valid(ch_valid), .ch_stall(ch_stall), .ch(ch),
    .res_valid(res_valid), .res_stall(res_stall),
    .status(status), .letter(letter), .conv_type(conv_type), .flag_bits(flag_bits),
    .length_bits(length_bits), .field_width(field_width), .precision(precision)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  parse_phase_t pp_phase = PP_HUNT;
  logic [FLAG_BITS-1:0] pp_flags = '0;
  int pp_width = 0;
  int pp_prec = -1;
  logic [LEN_BITS-1:0] pp_len = '0;

  spec_res_t want_specs[$];
  typed_spec_t typed_specs[$];
  logic [CH_BITS-1:0] frag_q[$];
  int errors = 0;
  int sent = 0;
  int hold_left = 0;
  bit calm = 1'b0;

  function automatic int add_dec(int acc, int d);
    if (acc > (ACC_MAX - d) / 10) return ACC_MAX;
    return acc * 10 + d;
  endfunction

  function automatic bit is_dig(logic [CH_BITS-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic int flag_slot(logic [CH_BITS-1:0] c);
    case (c)
      "#": return FL_ALT;
      "0": return FL_ZERO;
      "-": return FL_LEFT;
      " ": return FL_SPACE;
      "+": return FL_PLUS;
      "'": return FL_GROUP;
      default: return -1;
    endcase
  endfunction

  // Advance the parse state by one character; hit says whether a result comes out.
  function automatic void parse_char(input logic [CH_BITS-1:0] c, output bit hit,
                                     output spec_res_t r);
    parse_phase_t at;
    int slot;
    int d;
    logic [CONV_BITS-1:0] kind;
    logic [STATUS_BITS-1:0] st;
    hit = 1'b0;
    r = '0;
    at = pp_phase;
    d = int'(c) - int'(CH_ZERO);
    if (c == CH_NUL) begin
      hit = 1'b1;
      r = '{ST_END, CH_NUL, CT_NONE, 6'd0, 4'd0, 16'd0, PREC_NONE};
      pp_phase = PP_HUNT;
      return;
    end
    if (at == PP_HUNT) begin
      if (c == CH_PCT) begin
        pp_flags = '0;
        pp_width = 0;
        pp_prec = -1;
        pp_len = '0;
        pp_phase = PP_FLAGS;
      end
      return;
    end
    if (at == PP_FLAGS) begin
      slot = flag_slot(c);
      if (slot >= 0) begin
        pp_flags[slot] = 1'b1;
        return;
      end
      if (c >= CH_ONE && c <= CH_NINE) begin
        pp_width = d;
        pp_phase = PP_WIDTH;
        return;
      end
      at = PP_DOTCHK;
    end
    if (at == PP_WIDTH) begin
      if (is_dig(c)) begin
        pp_width = add_dec(pp_width, d);
        return;
      end
      at = PP_DOTCHK;
    end
    if (at == PP_DOTCHK) begin
      if (c == CH_DOT) begin
        pp_phase = PP_DOT;
        return;
      end
      at = PP_LEN;
    end
    if (at == PP_DOT) begin
      if (is_dig(c)) begin
        pp_prec = d;
        pp_phase = PP_PREC;
        return;
      end
      at = PP_LEN;
    end
    if (at == PP_PREC) begin
      if (is_dig(c)) begin
        pp_prec = add_dec((pp_prec < 0) ? 0 : pp_prec, d);
        return;
      end
      at = PP_LEN;
    end
    // at is PP_LEN here
    case (c)
      "h": begin pp_len[LN_SHORT] = 1'b1; pp_phase = PP_LEN; return; end
      "l": begin
        if (pp_len[LN_LONG]) pp_len[LN_LLONG] = 1'b1;
        else pp_len[LN_LONG] = 1'b1;
        pp_phase = PP_LEN;
        return;
      end
      "L": begin pp_len[LN_LDBL] = 1'b1; pp_phase = PP_LEN; return; end
      "q": begin pp_len[LN_LLONG] = 1'b1; pp_phase = PP_LEN; return; end
      "j", "z", "t": begin pp_phase = PP_LEN; return; end
      default: ;
    endcase

    pp_phase = PP_HUNT;
    st = ST_OK;
    case (c)
      "d", "i", "o", "u", "x", "X", "n": kind = CT_INT;
      "e", "E", "f", "F", "g", "G", "a", "A": kind = CT_FLOAT;
      "c": kind = CT_CHAR;
      "s": kind = CT_STR;
      "p": kind = CT_PTR;
      "C": begin kind = CT_CHAR; pp_len[LN_LONG] = 1'b1; end
      "S": begin kind = CT_STR; pp_len[LN_LONG] = 1'b1; end
      "%": return;
      default: begin kind = CT_NONE; st = ST_UNKNOWN; end
    endcase
    hit = 1'b1;
    r = '{st, c, kind, pp_flags, pp_len, pp_width[FWID_BITS-1:0], pp_prec[PREC_BITS-1:0]};
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  // Prediction on input acceptance, comparison on output acceptance.
  always @(posedge clk) begin
    spec_res_t pred;
    spec_res_t exp_r;
    typed_spec_t hint;
    bit pred_on;
    if (!rst && ch_valid && !ch_stall) begin
      hint = typed_specs.pop_front();
      parse_char(ch, pred_on, pred);
      if (pred_on) want_specs.push_back(hint.on ? hint.v : pred);
    end
    if (!rst && res_valid && !res_stall) begin
      if (want_specs.size() == 0) begin
        $error("unexpected result transaction: status %0d letter 0x%0h", status, letter);
        errors++;
      end else begin
        exp_r = want_specs.pop_front();
        check_field("status", exp_r.status, status);
        check_field("letter", exp_r.letter, letter);
        check_field("conv_type", exp_r.conv, conv_type);
        check_field("flag_bits", exp_r.flags, flag_bits);
        check_field("length_bits", exp_r.len, length_bits);
        check_field("field_width", exp_r.fwidth, field_width);
        check_field("precision", exp_r.prec, precision);
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when requested.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= !calm && ($urandom_range(99) < 12);
      end
    end
  end

  // Present one character at a negedge and return at the negedge after it is taken.
  task automatic put_char(input logic [CH_BITS-1:0] c, input bit typed, input spec_res_t v);
    typed_specs.push_back('{typed, v});
    while (!calm && $urandom_range(99) < 12) begin
      ch_valid <= 1'b0;
      @(negedge clk);
    end
    ch_valid <= 1'b1;
    ch <= c;
    do @(posedge clk); while (ch_stall);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic [CH_BITS-1:0] pick_text();
    logic [CH_BITS-1:0] c;
    do c = CH_BITS'($urandom_range(1, 255)); while (c == CH_PCT);
    return c;
  endfunction

  function automatic void push_digits(int n, bit lead_nonzero);
    for (int i = 0; i < n; i++) begin
      if (i == 0 && lead_nonzero) frag_q.push_back(CH_ZERO + CH_BITS'($urandom_range(1, 9)));
      else frag_q.push_back(CH_ZERO + CH_BITS'($urandom_range(0, 9)));
    end
  endfunction

  // Mostly well-formed specs with random content; some raw noise, text and broken specs.
  function automatic void make_fragment();
    string letters;
    string flag_chars;
    string mods;
    int kind;
    int n;
    int pick;
    letters = "diouxXneEfFgGaAcspCS";
    flag_chars = "#0- +'";
    mods = "hlLqjzt";
    frag_q.delete();
    kind = $urandom_range(99);
    if (kind < 10) begin
      n = $urandom_range(1, 6);
      repeat (n) frag_q.push_back(CH_BITS'($urandom));
    end else if (kind < 22) begin
      n = $urandom_range(1, 5);
      repeat (n) frag_q.push_back(pick_text());
      if ($urandom_range(3) == 0) frag_q.push_back(CH_NUL);
    end else begin
      frag_q.push_back(CH_PCT);
      n = $urandom_range(0, 3);
      repeat (n) frag_q.push_back(flag_chars[$urandom_range(0, 5)]);
      if ($urandom_range(1) == 0)
        push_digits(($urandom_range(15) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3), 1);
      if ($urandom_range(2) == 0) begin
        frag_q.push_back(CH_DOT);
        push_digits(($urandom_range(15) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3), 0);
      end
      n = ($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) frag_q.push_back(mods[$urandom_range(0, 6)]);
      pick = $urandom_range(99);
      if (pick < 74) frag_q.push_back(letters[$urandom_range(0, 19)]);
      else if (pick < 82) frag_q.push_back(CH_PCT);
      else if (pick < 87) frag_q.push_back("*");
      else if (pick < 94) frag_q.push_back(CH_BITS'($urandom));
      else frag_q.push_back(CH_NUL);
      // broken spec: string ends somewhere inside it
      if ($urandom_range(19) == 0) frag_q.insert($urandom_range(1, frag_q.size() - 1), CH_NUL);
    end
  endfunction

  dir_row_t dir_rows[6];

  initial begin
    bit did_hold;
    bit did_pause;
    did_hold = 1'b0;
    did_pause = 1'b0;
    dir_rows[0] = '{"", 1'b1, 1'b1,
                    '{ST_END, CH_NUL, CT_NONE, 6'd0, 4'd0, 16'd0, PREC_NONE}};
    dir_rows[1] = '{"%%", 1'b0, 1'b0, '0};
    dir_rows[2] = '{"%*", 1'b0, 1'b1,
                    '{ST_UNKNOWN, "*", CT_NONE, 6'd0, 4'd0, 16'd0, PREC_NONE}};
    // all flags, saturated width, bare dot, repeated l
    dir_rows[3] = '{"%#0- +'70000.lld", 1'b0, 1'b1,
                    '{ST_OK, "d", CT_INT, 6'h3F, 4'h6, 16'hFFFF, PREC_NONE}};
    dir_rows[4] = '{"%.70000S", 1'b0, 1'b1,
                    '{ST_OK, "S", CT_STR, 6'd0, 4'h2, 16'd0, 17'sd65535}};
    dir_rows[5] = '{"%hq", 1'b1, 1'b1,
                    '{ST_END, CH_NUL, CT_NONE, 6'd0, 4'd0, 16'd0, PREC_NONE}};

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[r]) begin
      for (int i = 0; i < dir_rows[r].txt.len(); i++)
        put_char(dir_rows[r].txt[i],
                 dir_rows[r].typed && !dir_rows[r].nul_end && i == dir_rows[r].txt.len() - 1,
                 dir_rows[r].want);
      if (dir_rows[r].nul_end) put_char(CH_NUL, dir_rows[r].typed, dir_rows[r].want);
    end

    while (sent < ITEMS) begin
      calm = (sent >= 200 && sent < 450);
      make_fragment();
      foreach (frag_q[i]) put_char(frag_q[i], 1'b0, '0);
      if (!did_hold && sent >= 700) begin
        did_hold = 1'b1;
        hold_left = 300;
      end
      if (!did_pause && sent >= 1200) begin
        did_pause = 1'b1;
        ch_valid <= 1'b0;
        do @(negedge clk); while (want_specs.size() != 0);
      end
    end
    calm = 1'b0;
    ch_valid <= 1'b0;

    while (want_specs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb_printf_spec_parser: PASS");
    end else begin
      $display("tb_printf_spec_parser: FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_printf_spec_parser: FAIL");
    $finish;
  end

endmodule
